FILE: rtl/esmc_pkg.sv
// shared types, codes and constants of the expedited sdo mailbox client
`timescale 1ns / 1ps
`default_nettype none

package esmc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_MAILBOX_ADDRESS = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_MAILBOX_SIZE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_IN_MAILBOX_ADDRESS  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_IN_MAILBOX_SIZE     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_RETRY_LIMIT         = 3'd5;

    // register reset values
    localparam logic [15:0] RST_DEVICE_ADDRESS      = 16'd0;
    localparam logic [15:0] RST_OUT_MAILBOX_ADDRESS = 16'd4096;
    localparam logic [15:0] RST_OUT_MAILBOX_SIZE    = 16'd128;
    localparam logic [15:0] RST_IN_MAILBOX_ADDRESS  = 16'd4352;
    localparam logic [15:0] RST_IN_MAILBOX_SIZE     = 16'd128;
    localparam logic [7:0]  RST_RETRY_LIMIT         = 8'd10;

    // input function codes
    localparam logic [1:0] FUNC_START_WRITE = 2'd0;
    localparam logic [1:0] FUNC_START_READ  = 2'd1;
    localparam logic [1:0] FUNC_REPLY       = 2'd2;
    localparam logic [1:0] FUNC_TICK        = 2'd3;

    // result kinds
    localparam logic [2:0] KIND_ISSUE     = 3'd0;
    localparam logic [2:0] KIND_WAIT      = 3'd1;
    localparam logic [2:0] KIND_DONE      = 3'd2;
    localparam logic [2:0] KIND_ABORT     = 3'd3;
    localparam logic [2:0] KIND_EXHAUSTED = 3'd4;

    // mailbox message types accepted as a response
    localparam logic [3:0] TYPE_SDO_REQ  = 4'd2;
    localparam logic [3:0] TYPE_SDO_RESP = 4'd3;

    // sdo command bytes and fields
    localparam logic [7:0] CMD_UPLOAD      = 8'h40;
    localparam logic [7:0] CMD_DOWNLOAD    = 8'h23;
    localparam logic [7:0] CMD_SIZE_MASK   = 8'h0C;
    localparam logic [7:0] CMD_ABORT_BIT   = 8'h80;
    localparam logic [1:0] SIZE_ONE_BYTE   = 2'd3;
    localparam logic [1:0] SIZE_TWO_BYTES  = 2'd2;
    localparam logic [2:0] LEN_FULL        = 3'd4;
    localparam logic [7:0] TRIES_MAX       = 8'hFF;

    typedef struct packed {
        logic [15:0] device_address;
        logic [15:0] out_mailbox_address;
        logic [15:0] out_mailbox_size;
        logic [15:0] in_mailbox_address;
        logic [15:0] in_mailbox_size;
        logic [7:0]  retry_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] object_index;
        logic [7:0]  object_subindex;
        logic [2:0]  write_length;
        logic [31:0] data_word;
        logic [15:0] reply_counter;
        logic [3:0]  reply_type;
        logic [7:0]  reply_command;
    } item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic        bus_write;
        logic [15:0] bus_device;
        logic [15:0] bus_offset;
        logic [15:0] bus_length;
        logic [7:0]  sdo_command;
        logic [15:0] sdo_index_out;
        logic [7:0]  sdo_subindex_out;
        logic [31:0] result_data;
        logic [7:0]  abort_class;
        logic [7:0]  abort_code;
    } res_t;

endpackage

`default_nettype wire

FILE: rtl/esmc_cfg_regs.sv
// configuration register file of the expedited sdo mailbox client
`timescale 1ns / 1ps
`default_nettype none

module esmc_cfg_regs
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [esmc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [esmc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output esmc_pkg::cfg_t                          cfg
);

    esmc_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_address      <= esmc_pkg::RST_DEVICE_ADDRESS;
            cfg_reg.out_mailbox_address <= esmc_pkg::RST_OUT_MAILBOX_ADDRESS;
            cfg_reg.out_mailbox_size    <= esmc_pkg::RST_OUT_MAILBOX_SIZE;
            cfg_reg.in_mailbox_address  <= esmc_pkg::RST_IN_MAILBOX_ADDRESS;
            cfg_reg.in_mailbox_size     <= esmc_pkg::RST_IN_MAILBOX_SIZE;
            cfg_reg.retry_limit         <= esmc_pkg::RST_RETRY_LIMIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                esmc_pkg::REG_DEVICE_ADDRESS:      cfg_reg.device_address      <= cfg_data;
                esmc_pkg::REG_OUT_MAILBOX_ADDRESS: cfg_reg.out_mailbox_address <= cfg_data;
                esmc_pkg::REG_OUT_MAILBOX_SIZE:    cfg_reg.out_mailbox_size    <= cfg_data;
                esmc_pkg::REG_IN_MAILBOX_ADDRESS:  cfg_reg.in_mailbox_address  <= cfg_data;
                esmc_pkg::REG_IN_MAILBOX_SIZE:     cfg_reg.in_mailbox_size     <= cfg_data;
                esmc_pkg::REG_RETRY_LIMIT:         cfg_reg.retry_limit         <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: rtl/esmc_core.sv
// input register and transaction state machine of the expedited sdo mailbox client
`timescale 1ns / 1ps
`default_nettype none

module esmc_core
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire esmc_pkg::cfg_t cfg,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire esmc_pkg::item_t in_item,
    input  wire logic           space,
    output logic                res_valid,
    output esmc_pkg::res_t      res
);

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_INBOX      = 3'd1,
        PH_REQ        = 3'd2,
        PH_POLL       = 3'd3,
        PH_WAIT_OUTER = 3'd4,
        PH_WAIT_INNER = 3'd5
    } phase_t;

    logic            s1_valid_reg;
    esmc_pkg::item_t s1_item_reg;
    logic            fire;

    phase_t          phase_reg, phase_next;
    logic            is_read_reg, is_read_next;
    logic [7:0]      outer_reg, outer_next;
    logic [7:0]      inner_reg, inner_next;
    logic [15:0]     index_reg, index_next;
    logic [7:0]      subindex_reg, subindex_next;
    logic [31:0]     value_reg, value_next;
    logic [2:0]      length_reg, length_next;

    logic            emit;
    logic            go_outer;
    logic            go_next_outer;
    logic            go_inner;
    logic [2:0]      start_len;
    logic [1:0]      size_bits;
    logic [1:0]      read_size;

    function automatic esmc_pkg::res_t mk_issue(
        input logic        wr,
        input logic [15:0] dev,
        input logic [15:0] off,
        input logic [15:0] len,
        input logic [7:0]  cmd,
        input logic [15:0] idx,
        input logic [7:0]  sub,
        input logic [31:0] data
    );
        esmc_pkg::res_t r;
        r                  = '0;
        r.kind             = esmc_pkg::KIND_ISSUE;
        r.bus_write        = wr;
        r.bus_device       = dev;
        r.bus_offset       = off;
        r.bus_length       = len;
        r.sdo_command      = cmd;
        r.sdo_index_out    = idx;
        r.sdo_subindex_out = sub;
        r.result_data      = data;
        return r;
    endfunction

    assign fire     = s1_valid_reg && space;
    assign in_ready = !s1_valid_reg || space;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg <= in_item;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        is_read_next  = is_read_reg;
        outer_next    = outer_reg;
        inner_next    = inner_reg;
        index_next    = index_reg;
        subindex_next = subindex_reg;
        value_next    = value_reg;
        length_next   = length_reg;
        emit          = 1'b0;
        go_outer      = 1'b0;
        go_next_outer = 1'b0;
        go_inner      = 1'b0;
        res           = '0;
        size_bits     = '0;
        read_size     = s1_item_reg.reply_command[3:2];
        start_len     = s1_item_reg.write_length;
        if (start_len == 3'd0 || start_len > esmc_pkg::LEN_FULL)
        begin
            start_len = esmc_pkg::LEN_FULL;
        end

        unique case (s1_item_reg.func) inside
            esmc_pkg::FUNC_START_WRITE, esmc_pkg::FUNC_START_READ:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    emit          = 1'b1;
                    is_read_next  = (s1_item_reg.func == esmc_pkg::FUNC_START_READ);
                    index_next    = s1_item_reg.object_index;
                    subindex_next = s1_item_reg.object_subindex;
                    length_next   = is_read_next ? 3'd0 : start_len;
                    value_next    = is_read_next ? 32'd0 : s1_item_reg.data_word;
                    outer_next    = 8'd0;
                    inner_next    = 8'd0;
                    go_outer      = 1'b1;
                end
            end
            esmc_pkg::FUNC_REPLY:
            begin
                if (phase_reg == PH_INBOX)
                begin
                    emit       = 1'b1;
                    phase_next = PH_REQ;
                    if (is_read_reg)
                    begin
                        res = mk_issue(1'b1, cfg.device_address, cfg.out_mailbox_address,
                                       cfg.out_mailbox_size, esmc_pkg::CMD_UPLOAD,
                                       index_reg, subindex_reg, 32'd0);
                    end
                    else
                    begin
                        size_bits = 2'(esmc_pkg::LEN_FULL - length_reg);
                        res = mk_issue(1'b1, cfg.device_address, cfg.out_mailbox_address,
                                       cfg.out_mailbox_size,
                                       esmc_pkg::CMD_DOWNLOAD
                                       | ({4'd0, size_bits, 2'd0} & esmc_pkg::CMD_SIZE_MASK),
                                       index_reg, subindex_reg, value_reg);
                    end
                end
                else if (phase_reg == PH_REQ)
                begin
                    emit = 1'b1;
                    if (s1_item_reg.reply_counter != 16'd0)
                    begin
                        inner_next = 8'd0;
                        go_inner   = 1'b1;
                    end
                    else
                    begin
                        res.kind   = esmc_pkg::KIND_WAIT;
                        phase_next = PH_WAIT_OUTER;
                    end
                end
                else if (phase_reg == PH_POLL)
                begin
                    emit = 1'b1;
                    if (s1_item_reg.reply_counter != 16'd0
                        && (s1_item_reg.reply_type == esmc_pkg::TYPE_SDO_REQ
                            || s1_item_reg.reply_type == esmc_pkg::TYPE_SDO_RESP))
                    begin
                        phase_next = PH_IDLE;
                        if (is_read_reg
                            && (s1_item_reg.reply_command & esmc_pkg::CMD_ABORT_BIT) != 8'd0)
                        begin
                            res.kind        = esmc_pkg::KIND_ABORT;
                            res.abort_class = s1_item_reg.data_word[31:24];
                            res.abort_code  = s1_item_reg.data_word[23:16];
                        end
                        else
                        begin
                            res.kind = esmc_pkg::KIND_DONE;
                            if (is_read_reg)
                            begin
                                if (read_size == esmc_pkg::SIZE_ONE_BYTE)
                                begin
                                    res.result_data = {24'd0, s1_item_reg.data_word[7:0]};
                                end
                                else if (read_size == esmc_pkg::SIZE_TWO_BYTES)
                                begin
                                    res.result_data = {16'd0, s1_item_reg.data_word[15:0]};
                                end
                                else
                                begin
                                    res.result_data = s1_item_reg.data_word;
                                end
                            end
                        end
                    end
                    else
                    begin
                        res.kind   = esmc_pkg::KIND_WAIT;
                        phase_next = PH_WAIT_INNER;
                    end
                end
            end
            default:
            begin
                if (phase_reg == PH_WAIT_OUTER)
                begin
                    emit          = 1'b1;
                    go_next_outer = 1'b1;
                end
                else if (phase_reg == PH_WAIT_INNER)
                begin
                    emit = 1'b1;
                    if (inner_reg != esmc_pkg::TRIES_MAX)
                    begin
                        inner_next = inner_reg + 8'd1;
                    end
                    go_inner = 1'b1;
                end
            end
        endcase

        // inner poll attempt, or fall back to the outer loop
        if (go_inner)
        begin
            if (inner_next >= cfg.retry_limit)
            begin
                go_next_outer = 1'b1;
            end
            else
            begin
                res = mk_issue(1'b0, cfg.device_address, cfg.in_mailbox_address,
                               cfg.in_mailbox_size, esmc_pkg::CMD_UPLOAD,
                               index_next, subindex_next, 32'd0);
                phase_next = PH_POLL;
            end
        end

        if (go_next_outer)
        begin
            if (outer_next != esmc_pkg::TRIES_MAX)
            begin
                outer_next = outer_next + 8'd1;
            end
            go_outer = 1'b1;
        end

        // outer attempt starts with an inbox flush, or gives up
        if (go_outer)
        begin
            if (outer_next >= cfg.retry_limit)
            begin
                res        = '0;
                res.kind   = esmc_pkg::KIND_EXHAUSTED;
                phase_next = PH_IDLE;
            end
            else
            begin
                res = mk_issue(1'b0, cfg.device_address, cfg.in_mailbox_address,
                               cfg.in_mailbox_size, esmc_pkg::CMD_UPLOAD,
                               index_next, subindex_next, 32'd0);
                phase_next = PH_INBOX;
            end
        end
    end

    assign res_valid = fire && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            is_read_reg  <= 1'b0;
            outer_reg    <= 8'd0;
            inner_reg    <= 8'd0;
            index_reg    <= 16'd0;
            subindex_reg <= 8'd0;
            value_reg    <= 32'd0;
            length_reg   <= 3'd0;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            is_read_reg  <= is_read_next;
            outer_reg    <= outer_next;
            inner_reg    <= inner_next;
            index_reg    <= index_next;
            subindex_reg <= subindex_next;
            value_reg    <= value_next;
            length_reg   <= length_next;
        end
    end

    a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.kind == esmc_pkg::KIND_DONE || res.kind == esmc_pkg::KIND_ABORT
                      || res.kind == esmc_pkg::KIND_EXHAUSTED)
        |=> phase_reg == PH_IDLE)
        else $error("transaction end did not return to idle");

    a_wait_goes_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.kind == esmc_pkg::KIND_WAIT
        |=> phase_reg == PH_WAIT_OUTER || phase_reg == PH_WAIT_INNER)
        else $error("wait result without a wait phase");

    a_idle_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
        fire && phase_reg == PH_IDLE && s1_item_reg.func == esmc_pkg::FUNC_TICK
        |-> !res_valid)
        else $error("tick in idle gave a result");

    a_busy_start_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        fire && phase_reg != PH_IDLE
        && (s1_item_reg.func == esmc_pkg::FUNC_START_WRITE
            || s1_item_reg.func == esmc_pkg::FUNC_START_READ)
        |=> $stable(phase_reg) && $stable(index_reg) && $stable(outer_reg))
        else $error("start while busy changed state");

endmodule

`default_nettype wire

FILE: rtl/esmc_out_reg.sv
// result register of the expedited sdo mailbox client
`timescale 1ns / 1ps
`default_nettype none

module esmc_out_reg
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       res_valid,
    input  wire esmc_pkg::res_t res,
    output logic            space,
    output logic            out_valid,
    input  wire logic       out_ready,
    output esmc_pkg::res_t  out_res
);

    logic           valid_reg;
    esmc_pkg::res_t res_reg;

    assign space = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (space)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (space && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

FILE: rtl/expedited_sdo_mailbox_client_unit.sv
// top level of the expedited sdo mailbox client
// a result is computed from the input register and offered from the result register
// throughput: one item per cycle while the result register has space, set by the state
// update between the input register and the result register
// an item that causes no result leaves the input register once the result register has space
// reset: asynchronous, clears the phase, retry counters, held request and all
// valid flags; configuration registers return to their reset values
`timescale 1ns / 1ps
`default_nettype none

module expedited_sdo_mailbox_client_unit
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [esmc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [esmc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [1:0]                        func,
    input  wire logic [15:0]                       object_index,
    input  wire logic [7:0]                        object_subindex,
    input  wire logic [2:0]                        write_length,
    input  wire logic [31:0]                       data_word,
    input  wire logic [15:0]                       reply_counter,
    input  wire logic [3:0]                        reply_type,
    input  wire logic [7:0]                        reply_command,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [2:0]                             kind,
    output logic                                   bus_write,
    output logic [15:0]                            bus_device,
    output logic [15:0]                            bus_offset,
    output logic [15:0]                            bus_length,
    output logic [7:0]                             sdo_command,
    output logic [15:0]                            sdo_index_out,
    output logic [7:0]                             sdo_subindex_out,
    output logic [31:0]                            result_data,
    output logic [7:0]                             abort_class,
    output logic [7:0]                             abort_code
);

    esmc_pkg::cfg_t  cfg;
    esmc_pkg::item_t in_item;
    esmc_pkg::res_t  res;
    esmc_pkg::res_t  out_res;
    logic            res_valid;
    logic            space;

    assign in_item.func            = func;
    assign in_item.object_index    = object_index;
    assign in_item.object_subindex = object_subindex;
    assign in_item.write_length    = write_length;
    assign in_item.data_word       = data_word;
    assign in_item.reply_counter   = reply_counter;
    assign in_item.reply_type      = reply_type;
    assign in_item.reply_command   = reply_command;

    esmc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    esmc_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .space     (space),
        .res_valid (res_valid),
        .res       (res)
    );

    esmc_out_reg u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign kind             = out_res.kind;
    assign bus_write        = out_res.bus_write;
    assign bus_device       = out_res.bus_device;
    assign bus_offset       = out_res.bus_offset;
    assign bus_length       = out_res.bus_length;
    assign sdo_command      = out_res.sdo_command;
    assign sdo_index_out    = out_res.sdo_index_out;
    assign sdo_subindex_out = out_res.sdo_subindex_out;
    assign result_data      = out_res.result_data;
    assign abort_class      = out_res.abort_class;
    assign abort_code       = out_res.abort_code;

endmodule

`default_nettype wire

FILE: sim/expedited_sdo_mailbox_client_unit_test.sv
// testbench of the expedited sdo mailbox client: directed and random transfers checked on a predictor
`timescale 1ns / 1ps

module expedited_sdo_mailbox_client_unit_test;

    import esmc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INBOX,
        ST_REQUEST,
        ST_POLL,
        ST_WAIT_OUTER,
        ST_WAIT_INNER
    } txn_phase_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [1:0]             func;
    logic [15:0]            object_index;
    logic [7:0]             object_subindex;
    logic [2:0]             write_length;
    logic [31:0]            data_word;
    logic [15:0]            reply_counter;
    logic [3:0]             reply_type;
    logic [7:0]             reply_command;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [2:0]             kind;
    logic                   bus_write;
    logic [15:0]            bus_device;
    logic [15:0]            bus_offset;
    logic [15:0]            bus_length;
    logic [7:0]             sdo_command;
    logic [15:0]            sdo_index_out;
    logic [7:0]             sdo_subindex_out;
    logic [31:0]            result_data;
    logic [7:0]             abort_class;
    logic [7:0]             abort_code;

    expedited_sdo_mailbox_client_unit dut (.*);

    // predictor state
    cfg_t       shadow_cfg;
    txn_phase_t phase;
    logic       is_read;
    logic [7:0] outer_tries;
    logic [7:0] inner_tries;
    logic [15:0] held_index;
    logic [7:0] held_sub;
    logic [31:0] held_value;
    logic [2:0] held_length;

    res_t expected_results [$];

    int idle_pct;
    int stall_pct;
    int fail_pct;
    int mismatches;
    int items_accepted;
    int results_seen;
    int kind_count [8];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic res_t datagram(logic wr, logic [15:0] off, logic [15:0] len,
                                      logic [7:0] cmd, logic [31:0] value);
        res_t r;
        r = '0;
        r.kind = KIND_ISSUE;
        r.bus_write = wr;
        r.bus_device = shadow_cfg.device_address;
        r.bus_offset = off;
        r.bus_length = len;
        r.sdo_command = cmd;
        r.sdo_index_out = held_index;
        r.sdo_subindex_out = held_sub;
        r.result_data = value;
        return r;
    endfunction

    function automatic res_t inbox_or_give_up();
        res_t r;
        r = '0;
        if (outer_tries >= shadow_cfg.retry_limit)
        begin
            r.kind = KIND_EXHAUSTED;
            phase = ST_IDLE;
        end
        else
        begin
            r = datagram(1'b0, shadow_cfg.in_mailbox_address, shadow_cfg.in_mailbox_size,
                         CMD_UPLOAD, '0);
            phase = ST_INBOX;
        end
        return r;
    endfunction

    function automatic res_t next_outer_attempt();
        if (outer_tries != TRIES_MAX)
            outer_tries = outer_tries + 8'd1;
        return inbox_or_give_up();
    endfunction

    function automatic res_t poll_or_fall_back();
        res_t r;
        if (inner_tries >= shadow_cfg.retry_limit)
            r = next_outer_attempt();
        else
        begin
            r = datagram(1'b0, shadow_cfg.in_mailbox_address, shadow_cfg.in_mailbox_size,
                         CMD_UPLOAD, '0);
            phase = ST_POLL;
        end
        return r;
    endfunction

    function automatic logic predict_client(input item_t it, output res_t r);
        logic [2:0] len;
        logic [7:0] unused_bytes;
        r = '0;
        if (it.func == FUNC_START_WRITE || it.func == FUNC_START_READ)
        begin
            if (phase != ST_IDLE)
                return 1'b0;
            is_read = (it.func == FUNC_START_READ);
            held_index = it.object_index;
            held_sub = it.object_subindex;
            len = it.write_length;
            if (len == '0 || len > LEN_FULL)
                len = LEN_FULL;
            held_length = is_read ? '0 : len;
            held_value = is_read ? '0 : it.data_word;
            outer_tries = '0;
            inner_tries = '0;
            r = inbox_or_give_up();
            return 1'b1;
        end
        if (it.func == FUNC_REPLY)
        begin
            case (phase)
                ST_INBOX:
                begin
                    if (is_read)
                        r = datagram(1'b1, shadow_cfg.out_mailbox_address,
                                     shadow_cfg.out_mailbox_size, CMD_UPLOAD, '0);
                    else
                    begin
                        unused_bytes = 8'(LEN_FULL) - 8'(held_length);
                        r = datagram(1'b1, shadow_cfg.out_mailbox_address,
                                     shadow_cfg.out_mailbox_size,
                                     CMD_DOWNLOAD | ((unused_bytes << 2) & CMD_SIZE_MASK),
                                     held_value);
                    end
                    phase = ST_REQUEST;
                    return 1'b1;
                end
                ST_REQUEST:
                begin
                    if (it.reply_counter != '0)
                    begin
                        inner_tries = '0;
                        r = poll_or_fall_back();
                    end
                    else
                    begin
                        r.kind = KIND_WAIT;
                        phase = ST_WAIT_OUTER;
                    end
                    return 1'b1;
                end
                ST_POLL:
                begin
                    if (it.reply_counter != '0 &&
                        (it.reply_type == TYPE_SDO_REQ || it.reply_type == TYPE_SDO_RESP))
                    begin
                        phase = ST_IDLE;
                        if (is_read && (it.reply_command & CMD_ABORT_BIT) != '0)
                        begin
                            r.kind = KIND_ABORT;
                            r.abort_class = it.data_word[31:24];
                            r.abort_code = it.data_word[23:16];
                        end
                        else
                        begin
                            r.kind = KIND_DONE;
                            if (is_read)
                            begin
                                case (it.reply_command[3:2])
                                    SIZE_ONE_BYTE:  r.result_data = {24'h0, it.data_word[7:0]};
                                    SIZE_TWO_BYTES: r.result_data = {16'h0, it.data_word[15:0]};
                                    default:        r.result_data = it.data_word;
                                endcase
                            end
                        end
                    end
                    else
                    begin
                        r.kind = KIND_WAIT;
                        phase = ST_WAIT_INNER;
                    end
                    return 1'b1;
                end
                default: return 1'b0;
            endcase
        end
        if (phase == ST_WAIT_OUTER)
        begin
            r = next_outer_attempt();
            return 1'b1;
        end
        if (phase == ST_WAIT_INNER)
        begin
            if (inner_tries != TRIES_MAX)
                inner_tries = inner_tries + 8'd1;
            r = poll_or_fall_back();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            if (mismatches < 10)
                $display("mismatch on %s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            kind_count[kind]++;
            if (expected_results.size() == 0)
            begin
                if (mismatches < 10)
                    $display("result of kind %0d with nothing expected", kind);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                compare_field("kind", want.kind, kind);
                compare_field("bus_write", want.bus_write, bus_write);
                compare_field("bus_device", want.bus_device, bus_device);
                compare_field("bus_offset", want.bus_offset, bus_offset);
                compare_field("bus_length", want.bus_length, bus_length);
                compare_field("sdo_command", want.sdo_command, sdo_command);
                compare_field("sdo_index_out", want.sdo_index_out, sdo_index_out);
                compare_field("sdo_subindex_out", want.sdo_subindex_out, sdo_subindex_out);
                compare_field("result_data", want.result_data, result_data);
                compare_field("abort_class", want.abort_class, abort_class);
                compare_field("abort_code", want.abort_code, abort_code);
            end
        end
    end

    task automatic send_item(input item_t it, output logic produced);
        res_t r;
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= it.func;
        object_index <= it.object_index;
        object_subindex <= it.object_subindex;
        write_length <= it.write_length;
        data_word <= it.data_word;
        reply_counter <= it.reply_counter;
        reply_type <= it.reply_type;
        reply_command <= it.reply_command;
        do @(posedge clk); while (in_ready !== 1'b1);
        items_accepted++;
        produced = predict_client(it, r);
        if (produced)
            expected_results = {expected_results, r};
    endtask

    task automatic push_item(input item_t it);
        logic produced;
        send_item(it, produced);
    endtask

    task automatic drain_client();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_register(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic load_settings(input cfg_t c);
        put_register(REG_DEVICE_ADDRESS, c.device_address);
        put_register(REG_OUT_MAILBOX_ADDRESS, c.out_mailbox_address);
        put_register(REG_OUT_MAILBOX_SIZE, c.out_mailbox_size);
        put_register(REG_IN_MAILBOX_ADDRESS, c.in_mailbox_address);
        put_register(REG_IN_MAILBOX_SIZE, c.in_mailbox_size);
        put_register(REG_RETRY_LIMIT, {8'h00, c.retry_limit});
        cfg_we <= 1'b0;
        shadow_cfg = c;
    endtask

    function automatic item_t random_item();
        item_t it;
        it.func = 2'($urandom_range(3));
        it.object_index = 16'($urandom);
        it.object_subindex = 8'($urandom);
        it.write_length = 3'($urandom_range(4));
        it.data_word = $urandom;
        it.reply_counter = 16'($urandom);
        it.reply_type = 4'($urandom);
        it.reply_command = 8'($urandom);
        return it;
    endfunction

    function automatic item_t start_item(logic [1:0] f, logic [15:0] idx, logic [7:0] sub,
                                         logic [2:0] len, logic [31:0] value);
        item_t it;
        it = random_item();
        it.func = f;
        it.object_index = idx;
        it.object_subindex = sub;
        it.write_length = len;
        it.data_word = value;
        return it;
    endfunction

    function automatic item_t reply_item(logic [15:0] counter, logic [3:0] mtype,
                                         logic [7:0] cmd, logic [31:0] payload);
        item_t it;
        it = random_item();
        it.func = FUNC_REPLY;
        it.reply_counter = counter;
        it.reply_type = mtype;
        it.reply_command = cmd;
        it.data_word = payload;
        return it;
    endfunction

    function automatic item_t tick_item();
        item_t it;
        it = random_item();
        it.func = FUNC_TICK;
        return it;
    endfunction

    function automatic cfg_t random_settings();
        cfg_t c;
        c.device_address = 16'($urandom);
        c.out_mailbox_address = 16'($urandom);
        c.out_mailbox_size = 16'($urandom);
        c.in_mailbox_address = 16'($urandom);
        c.in_mailbox_size = 16'($urandom);
        case ($urandom_range(3))
            0:       c.retry_limit = 8'd1;
            1:       c.retry_limit = 8'd2;
            2:       c.retry_limit = 8'd3;
            default: c.retry_limit = 8'($urandom_range(1, 255));
        endcase
        return c;
    endfunction

    // mostly the item the transaction waits for, with some noise
    function automatic item_t next_in_transaction();
        item_t it;
        logic [3:0] other_type;
        it = random_item();
        if ($urandom_range(99) < 8)
            return it;
        case (phase)
            ST_IDLE:
            begin
                it.func = $urandom_range(1) ? FUNC_START_READ : FUNC_START_WRITE;
                if ($urandom_range(9) == 0)
                    it.write_length = 3'($urandom_range(7));
            end
            ST_INBOX: it.func = FUNC_REPLY;
            ST_REQUEST:
            begin
                it.func = FUNC_REPLY;
                it.reply_counter = ($urandom_range(99) < fail_pct) ?
                                   16'h0 : 16'($urandom_range(1, 65535));
            end
            ST_POLL:
            begin
                it.func = FUNC_REPLY;
                it.reply_counter = 16'($urandom_range(1, 65535));
                it.reply_type = $urandom_range(1) ? TYPE_SDO_REQ : TYPE_SDO_RESP;
                if ($urandom_range(99) < fail_pct)
                begin
                    if ($urandom_range(1))
                        it.reply_counter = 16'h0;
                    else
                    begin
                        other_type = 4'($urandom);
                        while (other_type == TYPE_SDO_REQ || other_type == TYPE_SDO_RESP)
                            other_type = 4'($urandom);
                        it.reply_type = other_type;
                    end
                end
            end
            default: it.func = FUNC_TICK;
        endcase
        return it;
    endfunction

    task automatic test_write_with_retries();
        push_item(start_item(FUNC_START_WRITE, 16'hFFFF, 8'hFF, 3'd1, 32'hFFFF_FFFF));
        // start while busy
        push_item(start_item(FUNC_START_READ, 16'h0000, 8'h00, 3'd0, 32'h0));
        // inbox reply, counter not checked
        push_item(reply_item(16'h0, 4'h0, 8'h00, 32'h0));
        push_item(reply_item(16'h0, TYPE_SDO_RESP, 8'h00, 32'h0));
        push_item(tick_item());
        push_item(reply_item(16'hFFFF, 4'hF, 8'hFF, 32'hFFFF_FFFF));
        push_item(reply_item(16'hFFFF, TYPE_SDO_RESP, 8'h00, 32'h0));
        // wrong message type
        push_item(reply_item(16'h1, 4'hF, 8'h00, 32'h0));
        push_item(tick_item());
        // abort bit ignored on a write
        push_item(reply_item(16'h1, TYPE_SDO_REQ, CMD_ABORT_BIT, 32'h1234_5678));
    endtask

    task automatic test_read_sizes();
        push_item(start_item(FUNC_START_READ, 16'h8001, 8'h01, 3'd2, 32'h5555_AAAA));
        push_item(reply_item(16'h1, TYPE_SDO_RESP, 8'h00, 32'h0));
        push_item(reply_item(16'h1, TYPE_SDO_RESP, 8'h00, 32'h0));
        push_item(reply_item(16'h1, TYPE_SDO_RESP, 8'h4F, 32'hA5C3_96E1));
        push_item(reply_item(16'h1, TYPE_SDO_RESP, 8'h4B, 32'h0F0F_F0F0));
        push_item(tick_item());
        push_item(start_item(FUNC_START_READ, 16'h1018, 8'h02, 3'd4, 32'h0));
    endtask

    task automatic test_extreme_settings();
        cfg_t c;
        drain_client();
        c = '1;
        load_settings(c);
        push_item(start_item(FUNC_START_READ, 16'h6041, 8'h80, 3'd3, 32'h0));
        push_item(reply_item(16'h1, TYPE_SDO_RESP, 8'h00, 32'h0));
        push_item(reply_item(16'h1, TYPE_SDO_RESP, 8'h00, 32'h0));
        push_item(reply_item(16'h1, TYPE_SDO_REQ, CMD_ABORT_BIT, 32'hDEAD_BEEF));
    endtask

    task automatic test_retry_exhaustion();
        cfg_t c;
        drain_client();
        c = '0;
        c.retry_limit = 8'd1;
        load_settings(c);
        push_item(start_item(FUNC_START_READ, 16'h2000, 8'h10, 3'd1, 32'h0));
        push_item(reply_item(16'h1, TYPE_SDO_RESP, 8'h00, 32'h0));
        push_item(reply_item(16'h1, TYPE_SDO_RESP, 8'h00, 32'h0));
        push_item(reply_item(16'h0, TYPE_SDO_RESP, 8'h00, 32'h0));
        push_item(tick_item());
        // write length above four, left waiting on the request reply
        push_item(start_item(FUNC_START_WRITE, 16'h2001, 8'h20, 3'd7, 32'hCAFE_F00D));
        push_item(reply_item(16'h1, TYPE_SDO_RESP, 8'h00, 32'h0));
        drain_client();
        c.retry_limit = 8'd0;
        load_settings(c);
        push_item(reply_item(16'h1, TYPE_SDO_RESP, 8'h00, 32'h0));
        push_item(start_item(FUNC_START_WRITE, 16'h2002, 8'h30, 3'd0, 32'h1));
    endtask

    task automatic test_random_traffic();
        int idle_mix [4];
        int stall_mix [4];
        int answered;
        logic produced;
        idle_mix = '{0, 48, 0, 8};
        stall_mix = '{0, 0, 48, 8};
        for (int m = 0; m < 4; m++)
        begin
            drain_client();
            load_settings(random_settings());
            idle_pct = idle_mix[m];
            stall_pct = stall_mix[m];
            fail_pct = 15 + 10 * m;
            answered = 0;
            while (answered < 125)
            begin
                if ($urandom_range(149) == 0)
                    drain_client();
                send_item(next_in_transaction(), produced);
                if (produced)
                    answered++;
            end
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_DEVICE_ADDRESS;
        cfg_data <= '0;
        in_valid <= 1'b0;
        func <= FUNC_TICK;
        object_index <= '0;
        object_subindex <= '0;
        write_length <= '0;
        data_word <= '0;
        reply_counter <= '0;
        reply_type <= '0;
        reply_command <= '0;
        idle_pct = 0;
        stall_pct = 0;
        fail_pct = 20;
        mismatches = 0;
        items_accepted = 0;
        results_seen = 0;
        foreach (kind_count[k])
            kind_count[k] = 0;
        shadow_cfg.device_address = RST_DEVICE_ADDRESS;
        shadow_cfg.out_mailbox_address = RST_OUT_MAILBOX_ADDRESS;
        shadow_cfg.out_mailbox_size = RST_OUT_MAILBOX_SIZE;
        shadow_cfg.in_mailbox_address = RST_IN_MAILBOX_ADDRESS;
        shadow_cfg.in_mailbox_size = RST_IN_MAILBOX_SIZE;
        shadow_cfg.retry_limit = RST_RETRY_LIMIT;
        phase = ST_IDLE;
        is_read = 1'b0;
        outer_tries = '0;
        inner_tries = '0;
        held_index = '0;
        held_sub = '0;
        held_value = '0;
        held_length = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_write_with_retries();
        test_read_sizes();
        test_extreme_settings();
        test_retry_exhaustion();
        test_random_traffic();

        drain_client();
        repeat (8) @(posedge clk);
        $display("%0d transfers in, %0d results checked over four idling mixes and %s",
                 items_accepted, results_seen, "default, extreme and random registers");
        $display("results: %0d issue, %0d wait, %0d done, %0d abort, %0d exhausted",
                 kind_count[KIND_ISSUE], kind_count[KIND_WAIT], kind_count[KIND_DONE],
                 kind_count[KIND_ABORT], kind_count[KIND_EXHAUSTED]);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/esmc_pkg.sv
rtl/esmc_cfg_regs.sv
rtl/esmc_core.sv
rtl/esmc_out_reg.sv
rtl/expedited_sdo_mailbox_client_unit.sv
sim/expedited_sdo_mailbox_client_unit_test.sv
